[sv/smm_pkg.sv]
`timescale 1ns / 1ps
package smm_pkg;
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_MAP   = 2'd2;
    localparam logic [1:0] KIND_UNMAP = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NO_ID    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic take;     // latch input transaction
        logic exec;     // run checks and commit single-cycle work
        logic fill;     // write one zero word of the map fill
        logic finish;   // commit map bookkeeping and present result
        logic capture;  // register load data from the word RAM
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_map;     // latched transaction is a good map with fill
        logic map_ok;     // latched map passes checks
        logic fill_last;  // current fill word is the last one
        logic is_load;    // latched transaction is a good load
    } t_sts;
endpackage

[sv/segmented_memory_manager.sv]
`timescale 1ns / 1ps
// Sequence: load goes take, exec, RAM read; store, unmap and faults go take, exec;
// map goes take, exec, zero fill of map_length words, finish (exec alone when 0).
// Throughput: one transaction in flight; a new one is taken only back in idle,
// and exec or finish waits while a result is held by stall.
// Synchronous active-low reset: segment 0 mapped, free stack empty, next fresh
// id 1, program_words 0; word memory is not cleared.
module segmented_memory_manager #(
    parameter int SEGMENT_COUNT = 64,
    parameter int SEGMENT_WORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_segment_id,
    input  logic [7:0]  i_offset,
    input  logic [31:0] i_store_value,
    input  logic [8:0]  i_map_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_value,
    output logic [5:0]  o_new_segment,
    output logic [1:0]  o_status
);
    smm_pkg::t_cmd cmd;
    smm_pkg::t_sts sts;

    smm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    smm_dp #(.SEGMENT_COUNT(SEGMENT_COUNT), .SEGMENT_WORDS(SEGMENT_WORDS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_segment_id (i_segment_id),
        .i_offset     (i_offset),
        .i_store_value(i_store_value),
        .i_map_length (i_map_length),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_read_value (o_read_value),
        .o_new_segment(o_new_segment),
        .o_status     (o_status)
    );
endmodule

[sv/smm_ram.sv]
`timescale 1ns / 1ps
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/smm_ctrl.sv]
`timescale 1ns / 1ps
module smm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  smm_pkg::t_sts i_sts,
    output smm_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       out_free;

    // output register frees when empty or being taken
    assign out_free = !r_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_map) begin
                    n_state = S_FILL;
                end else if (out_free) begin
                    o_cmd.exec = 1'b1;
                    // load data comes registered from the RAM and is captured in S_READ
                    n_state    = i_sts.is_load ? S_READ : S_IDLE;
                    n_valid    = !i_sts.is_load;
                end
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
endmodule

[sv/smm_dp.sv]
`timescale 1ns / 1ps
module smm_dp #(
    parameter int SEGMENT_COUNT = 64,
    parameter int SEGMENT_WORDS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data,
    input  logic [1:0]    i_kind,
    input  logic [5:0]    i_segment_id,
    input  logic [7:0]    i_offset,
    input  logic [31:0]   i_store_value,
    input  logic [8:0]    i_map_length,
    input  smm_pkg::t_cmd i_cmd,
    output smm_pkg::t_sts o_sts,
    output logic [31:0]   o_read_value,
    output logic [5:0]    o_new_segment,
    output logic [1:0]    o_status
);
    localparam int IW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int WW = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
    localparam int LW = $clog2(SEGMENT_WORDS + 1);
    localparam int CW = $clog2(SEGMENT_COUNT + 1);
    localparam int AW = IW + WW;

    logic [8:0]  r_prog;
    logic [1:0]  r_kind;
    logic [5:0]  r_id;
    logic [7:0]  r_off;
    logic [31:0] r_val;
    logic [8:0]  r_len;

    logic [CW-1:0] r_top;
    logic [CW-1:0] r_fresh;

    logic [IW-1:0] r_nid;
    logic [LW-1:0] r_fcnt;
    logic [31:0]   r_rd;
    logic [5:0]    r_ns;
    logic [1:0]    r_st;

    logic          id_in;
    logic [IW-1:0] id_ix;
    logic          mapped;
    logic [8:0]    seg_len;
    logic          in_range;
    logic          len_ok;
    logic          id_free;
    logic [IW-1:0] pick_id;
    logic [1:0]    chk_st;
    logic          map_commit;
    logic          unmap_commit;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic          seg_we;
    logic [IW-1:0] seg_waddr;
    logic [LW:0]   seg_wdata;
    logic [IW-1:0] seg_raddr;
    logic [LW:0]   seg_rdata;
    logic [IW-1:0] stk_waddr;
    logic [IW-1:0] stk_raddr;
    logic [IW-1:0] stk_rdata;

    assign id_in   = ({26'd0, r_id} < SEGMENT_COUNT);
    assign id_ix   = IW'(r_id);
    // segment table entry {mapped, length}; ids at or above the fresh id were
    // never written, so they read as unmapped without any clearing pass
    assign mapped  = id_in && ((r_id == 6'd0)
                     || ((CW'(r_id) < r_fresh) && seg_rdata[LW]));
    assign seg_len = (r_id == 6'd0) ? r_prog : 9'(seg_rdata[LW-1:0]);
    assign in_range = ({1'b0, r_off} < seg_len);
    assign len_ok  = ({23'd0, r_len} <= SEGMENT_WORDS);
    assign id_free = (r_top != '0) || (r_fresh < CW'(SEGMENT_COUNT));
    assign pick_id = (r_top != '0) ? stk_rdata : IW'(r_fresh);

    always_comb begin
        chk_st = smm_pkg::ST_OK;
        case (r_kind)
            smm_pkg::KIND_LOAD, smm_pkg::KIND_STORE: begin
                if (!mapped) chk_st = smm_pkg::ST_UNMAPPED;
                else if (!in_range) chk_st = smm_pkg::ST_RANGE;
            end
            smm_pkg::KIND_MAP: begin
                if (!len_ok) chk_st = smm_pkg::ST_RANGE;
                else if (!id_free) chk_st = smm_pkg::ST_NO_ID;
            end
            smm_pkg::KIND_UNMAP: begin
                if (!mapped || r_id == 6'd0) chk_st = smm_pkg::ST_UNMAPPED;
                else if (r_top >= CW'(SEGMENT_COUNT)) chk_st = smm_pkg::ST_NO_ID;
            end
            default: chk_st = smm_pkg::ST_OK;
        endcase
    end

    assign o_sts.map_ok    = (r_kind == smm_pkg::KIND_MAP) && (chk_st == smm_pkg::ST_OK);
    assign o_sts.is_map    = o_sts.map_ok && (r_len != 9'd0) && (r_fcnt == '0);
    assign o_sts.fill_last = ({{(32-LW){1'b0}}, r_fcnt} + 32'd1 >= {23'd0, r_len});
    assign o_sts.is_load   = (r_kind == smm_pkg::KIND_LOAD) && (chk_st == smm_pkg::ST_OK);

    assign map_commit   = (i_cmd.exec && o_sts.map_ok) || i_cmd.finish;
    assign unmap_commit = i_cmd.exec && r_kind == smm_pkg::KIND_UNMAP
                          && chk_st == smm_pkg::ST_OK;

    // segment s, word w lives at s*SEGMENT_WORDS + w
    assign ram_we    = (i_cmd.exec && r_kind == smm_pkg::KIND_STORE
                        && chk_st == smm_pkg::ST_OK) || i_cmd.fill;
    assign ram_waddr = i_cmd.fill ? {r_nid, WW'(r_fcnt)} : {id_ix, WW'(r_off)};
    assign ram_wdata = i_cmd.fill ? 32'd0 : r_val;
    assign ram_raddr = {id_ix, WW'(r_off)};

    smm_ram #(.WIDTH(32), .DEPTH(SEGMENT_COUNT * SEGMENT_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // table is read at the take edge so the entry is ready in the check cycle
    assign seg_we    = map_commit || unmap_commit;
    assign seg_waddr = map_commit ? pick_id : id_ix;
    assign seg_wdata = map_commit ? {1'b1, LW'(r_len)} : '0;
    assign seg_raddr = i_cmd.take ? IW'(i_segment_id) : id_ix;

    smm_ram #(.WIDTH(LW + 1), .DEPTH(SEGMENT_COUNT)) u_seg_ram (
        .i_clk  (i_clk),
        .i_we   (seg_we),
        .i_waddr(seg_waddr),
        .i_wdata(seg_wdata),
        .i_raddr(seg_raddr),
        .o_rdata(seg_rdata)
    );

    // free stack top entry is always read; top is stable long before a map
    assign stk_waddr = IW'(r_top);
    assign stk_raddr = IW'(r_top - 1'b1);

    smm_ram #(.WIDTH(IW), .DEPTH(SEGMENT_COUNT)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (unmap_commit),
        .i_waddr(stk_waddr),
        .i_wdata(id_ix),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog  <= '0;
            r_top   <= '0;
            r_fresh <= CW'(1);
            r_fcnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prog <= (i_cfg_data > 9'(SEGMENT_WORDS)) ? 9'(SEGMENT_WORDS)
                                                           : i_cfg_data;
            end
            if (unmap_commit) begin
                r_top <= r_top + 1'b1;
            end
            if (o_sts.is_map) begin
                r_nid <= pick_id;
            end
            if (i_cmd.fill) begin
                r_fcnt <= r_fcnt + 1'b1;
            end
            if (map_commit) begin
                r_fcnt <= '0;
                if (r_top != '0) r_top <= r_top - 1'b1;
                else r_fresh <= r_fresh + 1'b1;
            end
        end
    end

    // map with zero length goes through exec directly; nid is pick_id there
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= i_kind;
            r_id   <= i_segment_id;
            r_off  <= i_offset;
            r_val  <= i_store_value;
            r_len  <= i_map_length;
        end
        if (i_cmd.exec || i_cmd.finish) begin
            r_rd <= 32'd0;
            r_ns <= (o_sts.map_ok) ? 6'(pick_id) : 6'd0;
            r_st <= chk_st;
        end
        if (i_cmd.capture) begin
            r_rd <= ram_rdata;
        end
    end

    assign o_read_value  = r_rd;
    assign o_new_segment = r_ns;
    assign o_status      = r_st;
endmodule

[sv/smm_checker.sv]
`timescale 1ns / 1ps
module smm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_read_value,
    input logic [5:0]  o_new_segment,
    input logic [1:0]  o_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
        && $stable(o_new_segment) && $stable(o_read_value))
        else $error("stalled result changed");
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != smm_pkg::ST_OK |-> o_read_value == 32'd0
        && o_new_segment == 6'd0)
        else $error("fault result carries data");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted transaction without going busy");
    a_map_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_segment != 6'd0 |-> o_status == smm_pkg::ST_OK
        && o_read_value == 32'd0)
        else $error("map result inconsistent");
endmodule

bind segmented_memory_manager smm_checker u_smm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_value (o_read_value),
    .o_new_segment(o_new_segment),
    .o_status     (o_status)
);
